// File: design/swm_pkg.sv
package swm_pkg;

  localparam int WindowMaxDef   = 64;
  localparam int SampleWidthDef = 32;
  localparam int CfgWidth       = 7;
  // Cells per first-level group of the median select tree.
  localparam int GroupSize      = 8;

  // Flags that a cell hands down to the cell below it.
  typedef struct packed {
    logic valid;
    logic eqv;
    logic gts;
  } dn_t;

  // Flags that a cell hands up to the cell above it, after the removal step.
  typedef struct packed {
    logic rvalid;
    logic rg;
  } up_t;

endpackage

// File: design/sliding_window_median.sv
// Running median filter over the last window_size signed samples, at most
// WindowMax of them. The sorted window lives in a row of compare-and-shift cells,
// one sample per cell, and an arrival-order ring memory tells which sample leaves
// next. Each output word is the sum of the two middle sorted samples, i.e. twice
// the median; nothing is produced until the window has filled, and a window size
// of zero passes every sample through doubled. An accepted word goes through, in
// order: the ring read of the outgoing sample, one parallel remove-and-insert pass
// over the cell row, and the registered median select and add. A new word is taken
// only once the previous one has reached the output register, so a word is never
// taken before the last one is through, and a stalled consumer holds the input.
// Writing window_size or sending a word with restart set empties the window.
module sliding_window_median #(
  parameter int WindowMax   = swm_pkg::WindowMaxDef,
  parameter int SampleWidth = swm_pkg::SampleWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          window_size_we_i,
  input  logic [swm_pkg::CfgWidth-1:0]  window_size_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SampleWidth:0]   median_twice_o
);

  localparam int CntW   = $clog2(WindowMax + 1);
  localparam int PtrW   = $clog2(WindowMax);
  localparam int CfgW   = swm_pkg::CfgWidth;
  localparam int CmpW   = (CntW > CfgW) ? CntW : CfgW;
  localparam int GrpSz  = swm_pkg::GroupSize;
  localparam int Groups = (WindowMax + GrpSz - 1) / GrpSz;
  localparam int PadN   = Groups * GrpSz;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RED,
    ST_OUT
  } state_e;

  state_e                        state_q;
  logic [CfgW-1:0]               ws_q;
  logic [CntW-1:0]               fill_q;
  logic [PtrW-1:0]               ptr_q;
  logic                          emit_q;
  logic                          out_valid_q;
  logic signed [SampleWidth:0]   median_q;
  logic signed [SampleWidth-1:0] s_q;

  logic [CmpW-1:0]               ws_ext;
  logic [CntW-1:0]               k;
  logic [CntW-1:0]               ptr_ext;
  logic [CntW-1:0]               ptr_inc;
  logic                          in_acc;
  logic                          full;
  logic                          upd;
  logic [PtrW-1:0]               rd_addr;
  logic [SampleWidth-1:0]        oldest;
  logic [CntW-1:0]               lo_idx;
  logic [CntW-1:0]               hi_idx;

  logic signed [SampleWidth-1:0] cell_val [WindowMax];
  logic signed [SampleWidth-1:0] cell_r   [WindowMax];
  swm_pkg::dn_t                  cell_dn  [WindowMax];
  swm_pkg::up_t                  cell_up  [WindowMax];

  logic [SampleWidth-1:0]        mlo [PadN];
  logic [SampleWidth-1:0]        mhi [PadN];
  logic [SampleWidth-1:0]        glo [Groups];
  logic [SampleWidth-1:0]        ghi [Groups];
  logic [SampleWidth-1:0]        plo_q [Groups];
  logic [SampleWidth-1:0]        phi_q [Groups];
  logic signed [SampleWidth-1:0] lo_v;
  logic signed [SampleWidth-1:0] hi_v;
  logic signed [SampleWidth:0]   med_d;

  assign ws_ext  = CmpW'(ws_q);
  assign k       = (ws_ext > CmpW'(WindowMax)) ? CntW'(WindowMax) : CntW'(ws_ext);
  assign ptr_ext = CntW'(ptr_q);
  assign ptr_inc = CntW'(ptr_ext + 1'b1);
  assign full    = (fill_q == k);

  // A window size write takes the cycle, so no word is taken alongside it.
  assign in_ready_o     = (state_q == ST_IDLE) && !window_size_we_i;
  assign in_acc         = in_valid_i && in_ready_o;
  assign out_valid_o    = out_valid_q;
  assign median_twice_o = median_q;

  assign rd_addr = (restart_i || ptr_ext >= k) ? '0 : ptr_q;
  assign upd     = (state_q == ST_EXEC) && (k != '0);

  swm_ring #(
    .Depth (WindowMax),
    .Width (SampleWidth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (upd),
    .waddr_i (ptr_q),
    .wdata_i (s_q),
    .re_i    (in_acc),
    .raddr_i (rd_addr),
    .rdata_o (oldest)
  );

  for (genvar i = 0; i < WindowMax; i++) begin : g_cell
    logic signed [SampleWidth-1:0] nxt_val;
    swm_pkg::dn_t                  nxt;
    logic signed [SampleWidth-1:0] prv_r;
    swm_pkg::up_t                  prv;

    if (i == WindowMax - 1) begin : g_top
      assign nxt_val = '0;
      assign nxt     = '0;
    end else begin : g_mid
      assign nxt_val = cell_val[i+1];
      assign nxt     = cell_dn[i+1];
    end

    if (i == 0) begin : g_bot
      assign prv_r = '0;
      assign prv   = '0;
    end else begin : g_up
      assign prv_r = cell_r[i-1];
      assign prv   = cell_up[i-1];
    end

    swm_cell #(
      .SampleWidth (SampleWidth)
    ) u_cell (
      .clk_i     (clk_i),
      .upd_i     (upd),
      .rem_i     (full),
      .sample_i  (s_q),
      .oldest_i  (oldest),
      .valid_i   (CntW'(i) < fill_q),
      .nxt_val_i (nxt_val),
      .nxt_i     (nxt),
      .prv_r_i   (prv_r),
      .prv_i     (prv),
      .val_o     (cell_val[i]),
      .dn_o      (cell_dn[i]),
      .r_o       (cell_r[i]),
      .up_o      (cell_up[i])
    );
  end

  // Median select: each cell masks its value by a position match, then a
  // registered two-level OR tree gathers the two middle entries.
  assign lo_idx = CntW'(k - 1'b1) >> 1;
  assign hi_idx = k >> 1;

  for (genvar i = 0; i < PadN; i++) begin : g_mask
    if (i < WindowMax) begin : g_real
      assign mlo[i] = (CntW'(i) == lo_idx) ? cell_val[i] : '0;
      assign mhi[i] = (CntW'(i) == hi_idx) ? cell_val[i] : '0;
    end else begin : g_pad
      assign mlo[i] = '0;
      assign mhi[i] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      glo[g] = '0;
      ghi[g] = '0;
      for (int j = 0; j < GrpSz; j++) begin
        glo[g] = glo[g] | mlo[g*GrpSz + j];
        ghi[g] = ghi[g] | mhi[g*GrpSz + j];
      end
    end
  end

  always_comb begin
    lo_v = '0;
    hi_v = '0;
    for (int g = 0; g < Groups; g++) begin
      lo_v = lo_v | plo_q[g];
      hi_v = hi_v | phi_q[g];
    end
  end

  always_comb begin
    if (k == '0) begin
      med_d = {s_q, 1'b0};
    end else begin
      med_d = {lo_v[SampleWidth-1], lo_v} + {hi_v[SampleWidth-1], hi_v};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_q <= sample_i;
    end
    if (state_q == ST_RED) begin
      plo_q <= glo;
      phi_q <= ghi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ws_q        <= CfgW'(1);
      fill_q      <= '0;
      ptr_q       <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
      median_q    <= '0;
    end else begin
      // In ST_OUT the output register is handled by the state itself.
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (window_size_we_i) begin
            ws_q   <= window_size_i;
            fill_q <= '0;
            ptr_q  <= '0;
          end else if (in_acc) begin
            if (restart_i) begin
              fill_q <= '0;
              ptr_q  <= '0;
            end else if (ptr_ext >= k) begin
              ptr_q <= '0;
            end
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (k == '0) begin
            emit_q <= 1'b1;
          end else begin
            emit_q <= full || (CntW'(fill_q + 1'b1) == k);
            if (!full) begin
              fill_q <= CntW'(fill_q + 1'b1);
            end
            ptr_q <= (ptr_inc >= k) ? '0 : PtrW'(ptr_inc);
          end
          state_q <= ST_RED;
        end
        ST_RED: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= emit_q;
            median_q    <= med_d;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/swm_cell.sv
module swm_cell #(
  parameter int SampleWidth = swm_pkg::SampleWidthDef
) (
  input  logic                          clk_i,
  input  logic                          upd_i,
  input  logic                          rem_i,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  logic signed [SampleWidth-1:0] oldest_i,
  input  logic                          valid_i,
  input  logic signed [SampleWidth-1:0] nxt_val_i,
  input  swm_pkg::dn_t                  nxt_i,
  input  logic signed [SampleWidth-1:0] prv_r_i,
  input  swm_pkg::up_t                  prv_i,
  output logic signed [SampleWidth-1:0] val_o,
  output swm_pkg::dn_t                  dn_o,
  output logic signed [SampleWidth-1:0] r_o,
  output swm_pkg::up_t                  up_o
);

  logic signed [SampleWidth-1:0] val_q, val_d;
  logic                          gtv;
  logic                          shl;

  assign val_o      = val_q;
  assign dn_o.valid = valid_i;
  assign dn_o.eqv   = (val_q == oldest_i);
  assign dn_o.gts   = (val_q > sample_i);
  assign gtv        = (val_q > oldest_i);

  // The last copy of the oldest word and everything above it move down one place.
  assign shl = rem_i && valid_i &&
               (gtv || (dn_o.eqv && !(nxt_i.valid && nxt_i.eqv)));

  assign r_o       = shl ? nxt_val_i : val_q;
  assign up_o.rg   = shl ? nxt_i.gts : dn_o.gts;
  assign up_o.rvalid = rem_i ? nxt_i.valid : valid_i;

  // Insertion: entries greater than the new word move up one place.
  always_comb begin
    if (prv_i.rvalid && prv_i.rg) begin
      val_d = prv_r_i;
    end else if (up_o.rvalid && up_o.rg) begin
      val_d = sample_i;
    end else if (up_o.rvalid) begin
      val_d = r_o;
    end else begin
      val_d = sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      val_q <= val_d;
    end
  end

endmodule

// File: design/swm_ring.sv
module swm_ring #(
  parameter int Depth = swm_pkg::WindowMaxDef,
  parameter int Width = swm_pkg::SampleWidthDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: verif/tb_sliding_window_median.sv
module tb_sliding_window_median;

  localparam int WinMax = swm_pkg::WindowMaxDef;
  localparam int SampleW = swm_pkg::SampleWidthDef;
  localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};
  localparam int RandomWords = 1900;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [SampleW:0] median_t;

  // Keeps its own copy of the window and predicts the doubled median.
  class median_scoreboard;
    sample_t sorted_win[WinMax];
    sample_t arrival[WinMax];
    int unsigned ring_ptr;
    int unsigned fill_cnt;
    logic [swm_pkg::CfgWidth-1:0] win_size;
    median_t expected_medians[$];
    int errors;

    function new();
      win_size = 1;
      ring_ptr = 0;
      fill_cnt = 0;
      errors = 0;
    endfunction

    function void set_window(logic [swm_pkg::CfgWidth-1:0] size);
      win_size = size;
      ring_ptr = 0;
      fill_cnt = 0;
    endfunction

    function int pending();
      return expected_medians.size();
    endfunction

    function void add_expected(median_t value);
      expected_medians = {expected_medians, value};
    endfunction

    function void insert_sorted(int unsigned n, sample_t value);
      int unsigned j;
      j = n;
      while (j > 0 && sorted_win[j-1] > value) begin
        sorted_win[j] = sorted_win[j-1];
        j--;
      end
      sorted_win[j] = value;
    endfunction

    function void note_word(sample_t value, logic restart);
      int unsigned k;
      int unsigned i;
      int unsigned j;
      median_t lo;
      median_t hi;
      k = (win_size > WinMax) ? WinMax : win_size;
      if (restart) begin
        ring_ptr = 0;
        fill_cnt = 0;
      end
      if (k == 0) begin
        lo = value;
        add_expected(lo + lo);
        return;
      end
      if (ring_ptr >= k) ring_ptr = 0;
      if (fill_cnt < k) begin
        insert_sorted(fill_cnt, value);
        fill_cnt++;
      end else begin
        // Exactly one copy of the leaving sample drops out, even among duplicates.
        for (i = 0; i < k; i++) begin
          if (sorted_win[i] == arrival[ring_ptr]) begin
            for (j = i; j + 1 < k; j++) sorted_win[j] = sorted_win[j+1];
            break;
          end
        end
        insert_sorted(k - 1, value);
      end
      arrival[ring_ptr] = value;
      ring_ptr++;
      if (ring_ptr >= k) ring_ptr = 0;
      if (fill_cnt < k) return;
      lo = sorted_win[(k - 1) / 2];
      hi = sorted_win[k / 2];
      add_expected(lo + hi);
    endfunction

    function void check_word(median_t got);
      median_t want;
      if (expected_medians.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output word %0d", got);
        return;
      end
      want = expected_medians.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("median mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic window_size_we_i = 1'b0;
  logic [swm_pkg::CfgWidth-1:0] window_size_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sample_t sample_i = '0;
  logic restart_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  median_t median_twice_o;

  median_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;

  sliding_window_median u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .window_size_we_i(window_size_we_i),
    .window_size_i   (window_size_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .restart_i       (restart_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .median_twice_o  (median_twice_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Consumer side; a long hold-off is counted down here.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_word(median_twice_o);
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
      default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
    endcase
  endtask

  task automatic send_word(input sample_t value, input logic restart);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    restart_i  <= restart;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    sb.note_word(value, restart);
  endtask

  // Waits for every expected word, then lets a word that yields nothing finish.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.pending() > 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [swm_pkg::CfgWidth-1:0] size);
    drain_results();
    window_size_we_i <= 1'b1;
    window_size_i    <= size;
    @(posedge clk_i);
    window_size_we_i <= 1'b0;
    sb.set_window(size);
  endtask

  function automatic sample_t rand_sample();
    sample_t v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 8) - 4;
      2: begin
        case ($urandom_range(0, 5))
          0: v = SampleMax;
          1: v = SampleMin;
          2: v = SampleMax - 1;
          3: v = SampleMin + 1;
          4: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom_range(0, 2000) - 1000;
    endcase
    return v;
  endfunction

  initial begin
    logic [swm_pkg::CfgWidth-1:0] size;
    logic [swm_pkg::CfgWidth-1:0] size_plan[5];
    int unsigned k;
    int n_words;
    int sent;
    int phase;
    sb = new();
    size_plan = '{7'd64, 7'd127, 7'd0, 7'd2, 7'd1};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Window of one after reset: every word comes back doubled.
    send_word(SampleMax, 1'b0);
    send_word(SampleMin, 1'b0);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(32'sd7, 1'b1);
    write_window(7'd0);
    send_word(SampleMax, 1'b0);
    send_word(SampleMin, 1'b0);
    send_word('1, 1'b1);
    // Duplicates in a window of three; only one copy of a 5 may leave.
    write_window(7'd3);
    send_word(32'sd5, 1'b0);
    send_word(32'sd5, 1'b0);
    send_word(-32'sd2, 1'b0);
    send_word(32'sd5, 1'b0);
    send_word(SampleMax, 1'b0);
    send_word(32'sd1, 1'b1);
    send_word(32'sd2, 1'b0);
    write_window(7'd2);
    send_word(SampleMin, 1'b0);
    send_word(SampleMax, 1'b0);
    send_word(SampleMin, 1'b0);
    send_word(SampleMin, 1'b0);

    // Long consumer hold-off so the pipeline backs up into the input.
    write_window(7'd1);
    set_idling(0);
    rx_hold_left = 300;
    sent = 0;
    for (int i = 0; i < 40; i++) begin
      send_word(rand_sample(), 1'b0);
      sent++;
    end

    phase = 0;
    while (sent < RandomWords) begin
      if (phase < 5) begin
        size = size_plan[phase];
      end else begin
        case ($urandom_range(0, 19))
          0: size = 7'd0;
          1: size = 7'd64;
          2: size = $urandom_range(65, 127);
          default: size = $urandom_range(1, 10);
        endcase
      end
      write_window(size);
      set_idling(phase % 4);
      k = (size > WinMax) ? WinMax : size;
      if (k >= WinMax) n_words = 200;
      else if (k == 0) n_words = 50;
      else n_words = $urandom_range(60, 140);
      for (int i = 0; i < n_words; i++) begin
        if (phase % 3 == 1 && i == n_words / 2) drain_results();
        send_word(rand_sample(), $urandom_range(0, 8 * k + 30) == 0);
        sent++;
      end
      phase++;
    end

    drain_results();
    if (sb.pending() != 0) sb.errors += sb.pending();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
